@@ rtl/ppc_pkg.sv @@
`default_nettype none

package ppc_pkg;

	localparam int COORD_W = 32;
	localparam int DIST_W  = 64;
	localparam int FRAC_W  = 32;
	localparam int MAG_W   = COORD_W + 1;
	localparam int PROD_W  = MAG_W + FRAC_W;
	localparam int ACC_W   = DIST_W + 2;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;

	typedef logic [IDX_W-1:0] cfg_index_t;

	localparam cfg_index_t CFG_NORMAL_X     = 2'd0;
	localparam cfg_index_t CFG_NORMAL_Y     = 2'd1;
	localparam cfg_index_t CFG_NORMAL_Z     = 2'd2;
	localparam cfg_index_t CFG_PLANE_OFFSET = 2'd3;

	localparam logic signed [COORD_W-1:0] NORMAL_Z_RESET = 32'sd65536;

	localparam logic KIND_KEPT  = 1'b0;
	localparam logic KIND_CROSS = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic signed [COORD_W-1:0] vertex_z;
		logic                      polygon_start;
	} vertex_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      out_kind;
		logic                      out_last;
	} vertex_out_t;

endpackage

`default_nettype wire

@@ rtl/ppc_mul.sv @@
`default_nettype none

module ppc_mul import ppc_pkg::*; (
	input  wire logic              clk,
	input  wire logic [MAG_W-1:0]  opa,
	input  wire logic [FRAC_W-1:0] opb,
	input  wire logic              neg,
	output logic      [PROD_W-1:0] prod,
	output logic                   prod_neg
);

	logic [MAG_W-1:0]  opa_s1;
	logic [FRAC_W-1:0] opb_s1;
	logic              neg_s1;
	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;
	logic [PROD_W-1:0] prod_c;

	// Unsigned magnitude product; the sign travels beside it.
	assign prod_c = PROD_W'(opa_s1) * PROD_W'(opb_s1);

	always_ff @(posedge clk) begin
		opa_s1  <= opa;
		opb_s1  <= opb;
		neg_s1  <= neg;
		prod_s2 <= prod_c;
		neg_s2  <= neg_s1;
	end

	assign prod     = prod_s2;
	assign prod_neg = neg_s2;

endmodule

`default_nettype wire

@@ rtl/ppc_frac_div.sv @@
`default_nettype none

module ppc_frac_div import ppc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIST_W-1:0] num,
	input  wire logic [DIST_W-1:0] den,
	output logic                   done,
	output logic      [FRAC_W-1:0] quot
);

	localparam int CNT_W = $clog2(FRAC_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] den_q;
	logic [FRAC_W-1:0] quot_q;
	logic [DIST_W-1:0] shifted;
	logic              take;

	// One restoring step per cycle. The bit shifted out of the remainder
	// forces a subtract, since the remainder then exceeds any divisor.
	assign shifted = {rem_q[DIST_W-2:0], 1'b0};
	assign take    = rem_q[DIST_W-1] || (shifted >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(FRAC_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= take ? (shifted - den_q) : shifted;
			quot_q <= {quot_q[FRAC_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

@@ rtl/polygon_plane_clipper.sv @@
// Clips a vertex stream against the plane a*x + b*y + c*z + d = 0.
// Input channel in_valid/in_ready/in_item carries one vertex per item; the
// caller repeats the first vertex of a polygon to close it. Output channel
// out_valid/out_ready/out_item carries zero, one or two result items per
// vertex: the kept previous vertex and/or the crossing point, with out_last
// set on the final one. The plane is written through cfg_we/cfg_index/
// cfg_data by the caller while the block is idle; this is not enforced.
// One vertex is worked on at a time and in_ready is low meanwhile. The
// shared 33x32 multiplier (three products for the distance, three for
// interpolation) and the 32-step radix-2 divider that forms the crossing
// fraction do the arithmetic; the divider runs while a kept vertex waits
// to be taken.
// A single output register holds a finished result; while the receiver
// stalls it, the block keeps working until it needs that register again.
// Reset restores the default plane (z >= 0 is inside), clears the stored
// vertex and makes the next vertex start a new polygon.

`default_nettype none

module polygon_plane_clipper import ppc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire vertex_in_t  in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output vertex_out_t      out_item,
	input  wire logic        cfg_we,
	input  wire cfg_index_t  cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL   = 8'b0000_0010,
		ST_DIST  = 8'b0000_0100,
		ST_CLASS = 8'b0000_1000,
		ST_KEEP  = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_LERP  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	logic signed [COORD_W-1:0] nx_q, ny_q, nz_q, d_q;
	logic signed [COORD_W-1:0] ex_q, ey_q, ez_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [DIST_W-1:0] prev_d_q;
	logic              prev_in_q;
	logic              await_q;
	logic              first_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DIST_W-1:0] de_q;
	logic              e_in_q;
	logic signed [COORD_W-1:0] rx_q, ry_q, rz_q;
	logic              out_valid_q;
	vertex_out_t       out_q;

	logic accept, slot_free, commit, load_keep, load_cross;
	logic div_start, div_done;
	logic [FRAC_W-1:0] t_frac;
	logic [DIST_W-1:0] div_num, div_den;

	logic [MAG_W-1:0]  mul_a;
	logic [FRAC_W-1:0] mul_b;
	logic              mul_neg;
	logic [PROD_W-1:0] prod;
	logic              prod_neg;

	logic signed [COORD_W-1:0] f_n, f_e, f_p, f_q, w_p;
	logic [COORD_W-1:0] abs_n, abs_e;
	logic [MAG_W-1:0]   delta, mag;
	logic [ACC_W-1:0]   term;
	logic [DIST_W-1:0]  de_sat;
	logic [PROD_W-1:0]  rounded;
	logic [MAG_W-1:0]   off, coord_new;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// Operand selection for the feed step (index cnt) and the write-back
	// step (index cnt - 2), which trails by the multiplier latency.
	always_comb begin
		case (cnt_q)
			3'd0: begin
				f_n = nx_q;
				f_e = ex_q;
				f_p = prev_in_q ? prev_x_q : ex_q;
				f_q = prev_in_q ? ex_q : prev_x_q;
			end
			3'd1: begin
				f_n = ny_q;
				f_e = ey_q;
				f_p = prev_in_q ? prev_y_q : ey_q;
				f_q = prev_in_q ? ey_q : prev_y_q;
			end
			default: begin
				f_n = nz_q;
				f_e = ez_q;
				f_p = prev_in_q ? prev_z_q : ez_q;
				f_q = prev_in_q ? ez_q : prev_z_q;
			end
		endcase
		case (cnt_q)
			3'd2:    w_p = prev_in_q ? prev_x_q : ex_q;
			3'd3:    w_p = prev_in_q ? prev_y_q : ey_q;
			default: w_p = prev_in_q ? prev_z_q : ez_q;
		endcase
	end

	assign abs_n = f_n[COORD_W-1] ? COORD_W'(-f_n) : COORD_W'(f_n);
	assign abs_e = f_e[COORD_W-1] ? COORD_W'(-f_e) : COORD_W'(f_e);
	assign delta = MAG_W'({f_q[COORD_W-1], f_q}) - MAG_W'({f_p[COORD_W-1], f_p});
	assign mag   = delta[MAG_W-1] ? (MAG_W'(0) - delta) : delta;

	always_comb begin
		if (state_q == ST_LERP) begin
			mul_a   = mag;
			mul_b   = t_frac;
			mul_neg = delta[MAG_W-1];
		end else begin
			mul_a   = {1'b0, abs_n};
			mul_b   = abs_e;
			mul_neg = f_n[COORD_W-1] ^ f_e[COORD_W-1];
		end
	end

	ppc_mul u_mul (
		.clk      (clk),
		.opa      (mul_a),
		.opb      (mul_b),
		.neg      (mul_neg),
		.prod     (prod),
		.prod_neg (prod_neg)
	);

	assign term = prod_neg ? (ACC_W'(0) - ACC_W'(prod)) : ACC_W'(prod);

	always_comb begin
		if (acc_q[ACC_W-1:DIST_W-1] == '0 || acc_q[ACC_W-1:DIST_W-1] == '1) begin
			de_sat = acc_q[DIST_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			de_sat = {1'b1, {(DIST_W-1){1'b0}}};
		end else begin
			de_sat = {1'b0, {(DIST_W-1){1'b1}}};
		end
	end

	// Round half away from zero on the magnitude, then apply the sign.
	assign rounded   = prod + PROD_W'(64'h8000_0000);
	assign off       = rounded[PROD_W-1:FRAC_W];
	assign coord_new = MAG_W'({w_p[COORD_W-1], w_p})
		+ (prod_neg ? (MAG_W'(0) - off) : off);

	// The inside end supplies the numerator; the denominator is the
	// distance span across the plane.
	assign div_num   = prev_in_q ? prev_d_q : de_q;
	assign div_den   = div_num - (prev_in_q ? de_q : prev_d_q);
	assign div_start = (state_q == ST_CLASS) && !first_q && (prev_in_q ^ e_in_q);

	ppc_frac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (t_frac)
	);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		commit     = 1'b0;
		load_keep  = 1'b0;
		load_cross = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL;
					cnt_d   = '0;
				end
			end
			ST_MUL: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 3'd4) begin
					state_d = ST_DIST;
				end
			end
			ST_DIST: begin
				state_d = ST_CLASS;
			end
			ST_CLASS: begin
				if (first_q || (!prev_in_q && !e_in_q)) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end else if (prev_in_q) begin
					state_d = ST_KEEP;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_KEEP: begin
				if (slot_free) begin
					load_keep = 1'b1;
					if (e_in_q) begin
						commit  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_LERP;
					cnt_d   = '0;
				end
			end
			ST_LERP: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 3'd4) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_cross = 1'b1;
					commit     = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
			nz_q        <= NORMAL_Z_RESET;
			d_q         <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			prev_d_q    <= '0;
			prev_in_q   <= 1'b0;
			await_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NORMAL_X:     nx_q <= cfg_data;
					CFG_NORMAL_Y:     ny_q <= cfg_data;
					CFG_NORMAL_Z:     nz_q <= cfg_data;
					CFG_PLANE_OFFSET: d_q  <= cfg_data;
					default:          d_q  <= d_q;
				endcase
			end
			if (commit) begin
				prev_x_q  <= ex_q;
				prev_y_q  <= ey_q;
				prev_z_q  <= ez_q;
				prev_d_q  <= de_q;
				prev_in_q <= e_in_q;
				await_q   <= 1'b0;
			end
			if (load_keep || load_cross) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ex_q    <= in_item.vertex_x;
			ey_q    <= in_item.vertex_y;
			ez_q    <= in_item.vertex_z;
			first_q <= in_item.polygon_start || await_q;
			acc_q   <= {{(ACC_W-COORD_W-16){d_q[COORD_W-1]}}, d_q, 16'h0000};
		end else if (state_q == ST_MUL && cnt_q >= 3'd2) begin
			acc_q <= acc_q + term;
		end
		if (state_q == ST_DIST) begin
			de_q   <= de_sat;
			e_in_q <= !de_sat[DIST_W-1];
		end
		if (state_q == ST_LERP) begin
			case (cnt_q)
				3'd2:    rx_q <= coord_new[COORD_W-1:0];
				3'd3:    ry_q <= coord_new[COORD_W-1:0];
				3'd4:    rz_q <= coord_new[COORD_W-1:0];
				default: rx_q <= rx_q;
			endcase
		end
		if (load_keep) begin
			out_q.out_x    <= prev_x_q;
			out_q.out_y    <= prev_y_q;
			out_q.out_z    <= prev_z_q;
			out_q.out_kind <= KIND_KEPT;
			out_q.out_last <= e_in_q;
		end else if (load_cross) begin
			out_q.out_x    <= rx_q;
			out_q.out_y    <= ry_q;
			out_q.out_z    <= rz_q;
			out_q.out_kind <= KIND_CROSS;
			out_q.out_last <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

@@ rtl/ppc_checker.sv @@
`default_nettype none

module ppc_checker import ppc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire vertex_out_t out_item
);

	// A stalled result must hold still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed or dropped while stalled");

	// The block works on one vertex at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after an item");

	// A crossing point always closes the results of its vertex.
	a_cross_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.out_kind == KIND_CROSS) |-> out_item.out_last)
		else $error("crossing point not marked as last result");

	// A result only appears while a vertex is being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result item appeared while the block was idle");

endmodule

bind polygon_plane_clipper ppc_checker u_ppc_checker (.*);

`default_nettype wire
